[hw/rtl/hsv2rgb_pkg.sv]
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by hsv2rgb_chan and hsv_to_rgb_converter.
package hsv2rgb_pkg;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_VALUE_LEVEL = 3'd0;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
    logic en5;
  } adv_t;

endpackage

[hw/rtl/hsv2rgb_chan.sv]
// One color channel of the converter: saturation lift, value scale, rounding.
// Four register stages driven by stage enables; depends on hsv2rgb_pkg.
module hsv2rgb_chan #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8
) (
  input  logic                      clk_i,
  input  hsv2rgb_pkg::adv_t         adv_i,
  input  logic [HUE_BITS:0]         ramp_i,
  input  logic [CHANNEL_BITS-1:0]   sat_i,
  input  logic [CHANNEL_BITS-1:0]   val_i,
  output logic [CHANNEL_BITS-1:0]   out_o
);
  import hsv2rgb_pkg::*;

  localparam int unsigned H  = HUE_BITS;
  localparam int unsigned C  = CHANNEL_BITS;
  localparam int unsigned PW = C + H;
  localparam int unsigned NW = 2 * C + H;
  localparam int unsigned QW = 2 * C;
  localparam int unsigned EW = C + 1;

  localparam logic [H:0]    HUE_ONE = (H + 1)'(1) << H;
  localparam logic [C-1:0]  CMAX    = {C{1'b1}};
  localparam logic [PW-1:0] DEN     = PW'(CMAX) << H;
  localparam logic [NW-1:0] RND     = NW'(CMAX) << (H - 1);

  logic [H:0]    inv_ramp;
  logic [PW-1:0] prod_d, prod_q;
  logic [PW-1:0] lift;
  logic [NW-1:0] num_d, num_q;
  logic [NW-1:0] sum;
  logic [QW-1:0] quo_d, quo_q;
  logic [QW:0]   est_sum;
  logic [EW-1:0] est_d, est_q;
  logic [QW:0]   est_mul;
  logic [QW:0]   rem;
  logic [EW-1:0] res;
  logic [C-1:0]  out_d, out_q;

  always_comb begin
    inv_ramp = HUE_ONE - ramp_i;
    prod_d   = PW'(sat_i) * PW'(inv_ramp);
    lift     = DEN - prod_q;
    num_d    = NW'(val_i) * NW'(lift);
    sum      = num_q + RND;
    quo_d    = sum[NW-1:H];
    est_sum  = (QW + 1)'(quo_d) + (QW + 1)'(quo_d[QW-1:C]);
    est_d    = est_sum[QW:C];
    est_mul  = ((QW + 1)'(est_q) << C) - (QW + 1)'(est_q);
    rem      = (QW + 1)'(quo_q) - est_mul;
    res      = est_q + EW'(rem >= (QW + 1)'(CMAX));
    out_d    = res[C-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.en2) begin
      prod_q <= prod_d;
    end
    if (adv_i.en3) begin
      num_q <= num_d;
    end
    if (adv_i.en4) begin
      quo_q <= quo_d;
      est_q <= est_d;
    end
    if (adv_i.en5) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

[hw/rtl/hsv_to_rgb_converter.sv]
// Top level of the HSV to RGB converter: stream ports, APB register, hue sectors.
// Depends on hsv2rgb_pkg and hsv2rgb_chan.
//
//  port group   dir  contents
//  s_axis_*     in   pixel: hue, saturation
//  m_axis_*     out  pixel: red, green, blue
//  APB          i/o  value_level at byte address 0
//
// Five register stages; one pixel per cycle while m_axis_tready holds the output unstalled.
// Stage one splits the hue into sector and position, stages two to five
// scale and round each channel in its own lane.
// Each stage holds while full and its successor is blocked; empty stages fill.
// Reset empties the pipeline and sets value_level to full scale.
module hsv_to_rgb_converter #(
  parameter int unsigned HUE_BITS     = 12,
  parameter int unsigned CHANNEL_BITS = 8,
  localparam int unsigned S_TDATA_W   = ((HUE_BITS + CHANNEL_BITS + 7) / 8) * 8,
  localparam int unsigned M_TDATA_W   = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [S_TDATA_W-1:0]                s_axis_tdata,  // hue, saturation
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [M_TDATA_W-1:0]                m_axis_tdata,  // red, green, blue
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hsv2rgb_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hsv2rgb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hsv2rgb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                pready
);
  import hsv2rgb_pkg::*;

  localparam int unsigned H = HUE_BITS;
  localparam int unsigned C = CHANNEL_BITS;
  localparam logic [H:0]   HUE_ONE = (H + 1)'(1) << H;
  localparam logic [C-1:0] CMAX    = {C{1'b1}};

  logic [C-1:0]   value_q;
  logic           cfg_wr;
  logic [4:0]     vld_q;
  logic           en1;
  adv_t           adv;

  logic [H-1:0]   hue_in;
  logic [C-1:0]   sat_in;
  logic [H+2:0]   scaled;
  logic [2:0]     sector_q;
  logic [H-1:0]   up_q;
  logic [C-1:0]   sat_q;
  logic [H:0]     up_ext, down;
  logic [H:0]     ramp_r, ramp_g, ramp_b;
  logic [C-1:0]   red, green, blue;

  // APB register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_VALUE_LEVEL);
  assign prdata = (paddr == ADDR_VALUE_LEVEL) ? APB_DATA_W'(value_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= CMAX;
    end else if (cfg_wr) begin
      value_q <= pwdata[C-1:0];
    end
  end

  // stage enables: advance when empty or when the next stage moves
  assign adv.en5      = !vld_q[4] || m_axis_tready;
  assign adv.en4      = !vld_q[3] || adv.en5;
  assign adv.en3      = !vld_q[2] || adv.en4;
  assign adv.en2      = !vld_q[1] || adv.en3;
  assign en1          = !vld_q[0] || adv.en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = vld_q[4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en1)     vld_q[0] <= s_axis_tvalid;
      if (adv.en2) vld_q[1] <= vld_q[0];
      if (adv.en3) vld_q[2] <= vld_q[1];
      if (adv.en4) vld_q[3] <= vld_q[2];
      if (adv.en5) vld_q[4] <= vld_q[3];
    end
  end

  // stage one: six times the hue gives sector and position
  always_comb begin
    hue_in = s_axis_tdata[H-1:0];
    sat_in = s_axis_tdata[H+C-1:H];
    scaled = ((H + 3)'(hue_in) << 2) + ((H + 3)'(hue_in) << 1);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sector_q <= scaled[H+2:H];
      up_q     <= scaled[H-1:0];
      sat_q    <= sat_in;
    end
  end

  // pick the ramp for each channel
  always_comb begin
    up_ext = (H + 1)'(up_q);
    down   = HUE_ONE - up_ext;
    case (sector_q)
      SEC_RED_YEL: begin
        ramp_r = HUE_ONE; ramp_g = up_ext;  ramp_b = '0;
      end
      SEC_YEL_GRN: begin
        ramp_r = down;    ramp_g = HUE_ONE; ramp_b = '0;
      end
      SEC_GRN_CYN: begin
        ramp_r = '0;      ramp_g = HUE_ONE; ramp_b = up_ext;
      end
      SEC_CYN_BLU: begin
        ramp_r = '0;      ramp_g = down;    ramp_b = HUE_ONE;
      end
      SEC_BLU_MAG: begin
        ramp_r = up_ext;  ramp_g = '0;      ramp_b = HUE_ONE;
      end
      default: begin
        ramp_r = HUE_ONE; ramp_g = '0;      ramp_b = down;
      end
    endcase
  end

  hsv2rgb_chan #(.HUE_BITS(HUE_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_chan_r (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .ramp_i (ramp_r),
    .sat_i  (sat_q),
    .val_i  (value_q),
    .out_o  (red)
  );

  hsv2rgb_chan #(.HUE_BITS(HUE_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_chan_g (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .ramp_i (ramp_g),
    .sat_i  (sat_q),
    .val_i  (value_q),
    .out_o  (green)
  );

  hsv2rgb_chan #(.HUE_BITS(HUE_BITS), .CHANNEL_BITS(CHANNEL_BITS)) u_chan_b (
    .clk_i  (clk_i),
    .adv_i  (adv),
    .ramp_i (ramp_b),
    .sat_i  (sat_q),
    .val_i  (value_q),
    .out_o  (blue)
  );

  assign m_axis_tdata = M_TDATA_W'({blue, green, red});

endmodule
